FILE: sv/keyed_binary_min_heap_macros.svh
// Assertion macros for the keyed binary min-heap.
`ifndef KEYED_BINARY_MIN_HEAP_MACROS_SVH
`define KEYED_BINARY_MIN_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define KBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heap check failed");
`define KBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heap check failed");
`else
`define KBH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KBH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/kbh_pkg.sv
// Package with types, constants and request codes of the keyed binary min-heap.
package kbh_pkg;
    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 64;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = 10;

    localparam logic [2:0] KIND_ADD     = 3'd0;
    localparam logic [2:0] KIND_SET     = 3'd1;
    localparam logic [2:0] KIND_DELETE  = 3'd2;
    localparam logic [2:0] KIND_SEARCH  = 3'd3;
    localparam logic [2:0] KIND_MIN     = 3'd4;
    localparam logic [2:0] KIND_MAX     = 3'd5;
    localparam logic [2:0] KIND_EXTRACT = 3'd6;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] key;
        logic [63:0]        value;
    } kbh_req_t;

    typedef struct packed {
        logic               status;
        logic signed [63:0] result_key;
        logic [POS_W-1:0]   position;
        logic [63:0]        result_value;
    } kbh_rsp_t;

    // One memory port: read or write at one address
    typedef struct packed {
        logic                   rd;
        logic                   wr;
        logic [IDX_W-1:0]       addr;
        logic signed [63:0]     wkey;
        logic [VALUE_WIDTH-1:0] wval;
    } kbh_mem_req_t;

    typedef struct packed {
        logic signed [63:0]     key;
        logic [VALUE_WIDTH-1:0] val;
    } kbh_entry_t;
endpackage

FILE: sv/keyed_binary_min_heap.sv
// Top level of the keyed binary min-heap: sequencer plus entry store.
//
// Usage: drive request (kind, key, value) and pulse start while busy is low;
// the transaction is taken at that edge. One result per transaction appears
// on result with done high for exactly one cycle; the receiver cannot stall.
// Requests: add, set, delete, search, min, max, extract.
// Each request steps through states over the single-port entry memory
// (one access per cycle, registered read data):
//   key lookup (add/set/delete/search): read and compare per entry scanned,
//   sift up: read parent, compare, write per level, sift down: check, read
//   left, read right (only if it exists), pick, compare, write per level,
//   max: read and compare per leaf, min: read the root and register it.
// A new request may start the cycle after done.
// Reset clears the entry count and the sequencer; memory contents are left
// as they are and are only read below the entry count. No clearing pass.
module keyed_binary_min_heap (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  kbh_pkg::kbh_req_t request,
    output logic              busy,
    output logic              done,
    output kbh_pkg::kbh_rsp_t result
);
    import kbh_pkg::*;
    `include "keyed_binary_min_heap_macros.svh"

    kbh_mem_req_t     mreq;
    kbh_entry_t       rdata;
    logic [CNT_W-1:0] count;

    kbh_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (request),
        .busy  (busy),
        .done  (done),
        .rsp   (result),
        .mreq  (mreq),
        .rdata (rdata),
        .count (count)
    );

    kbh_ram u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    `KBH_ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count <= CNT_W'(CAPACITY))
    `KBH_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `KBH_ASSERT_IMPL(a_mem_one_op, clk, rst_n, 1'b1, !(mreq.rd && mreq.wr))
endmodule

FILE: sv/kbh_ram.sv
// Single-port entry store: key and data word, registered read.
module kbh_ram (
    input  logic                 clk,
    input  kbh_pkg::kbh_mem_req_t req,
    output kbh_pkg::kbh_entry_t   rdata
);
    import kbh_pkg::*;

    kbh_entry_t mem [CAPACITY];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= '{key: req.wkey, val: req.wval};
        end
        else if (req.rd)
        begin
            rdata <= mem[req.addr];
        end
    end
endmodule

FILE: sv/kbh_ctrl.sv
// Sequencer: key search, sift up/down, max scan and result build over one RAM port.
module kbh_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  kbh_pkg::kbh_req_t     req,
    output logic                  busy,
    output logic                  done,
    output kbh_pkg::kbh_rsp_t     rsp,
    output kbh_pkg::kbh_mem_req_t mreq,
    input  kbh_pkg::kbh_entry_t   rdata,
    output logic [kbh_pkg::CNT_W-1:0] count
);
    import kbh_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FIND   = 5'd1;  // read entry idx
    localparam logic [4:0] S_FINDW  = 5'd2;  // compare entry
    localparam logic [4:0] S_DISP   = 5'd3;  // act on search result
    localparam logic [4:0] S_RDLAST = 5'd4;
    localparam logic [4:0] S_GOTLST = 5'd5;
    localparam logic [4:0] S_UPRD   = 5'd6;  // read parent
    localparam logic [4:0] S_UPCMP  = 5'd7;
    localparam logic [4:0] S_UPWR   = 5'd8;  // write parent entry into hole
    localparam logic [4:0] S_DNRDL  = 5'd9;
    localparam logic [4:0] S_DNRDR  = 5'd10;
    localparam logic [4:0] S_DNGL   = 5'd11;
    localparam logic [4:0] S_DNCMP  = 5'd12;
    localparam logic [4:0] S_DNWR   = 5'd13;
    localparam logic [4:0] S_PLACE  = 5'd14; // final write of carried entry
    localparam logic [4:0] S_RDROOT = 5'd15;
    localparam logic [4:0] S_ROOTW  = 5'd16;
    localparam logic [4:0] S_MXRD   = 5'd17;
    localparam logic [4:0] S_MXCMP  = 5'd18;
    localparam logic [4:0] S_MXOUT  = 5'd19;
    localparam logic [4:0] S_MXOW   = 5'd20;
    localparam logic [4:0] S_DONE   = 5'd21;
    localparam logic [4:0] S_DNCHK  = 5'd22;

    logic [4:0]            state_reg, state_next;
    kbh_req_t              req_reg, req_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;      // scan / sift position
    logic [CNT_W-1:0]      oth_reg, oth_next;      // parent or child position
    kbh_entry_t            cur_reg, cur_next;      // carried entry
    kbh_entry_t            lft_reg, lft_next;      // left child / best
    logic                  found_reg, found_next;
    logic                  moved_reg, moved_next;  // sift-up moved
    kbh_rsp_t              rsp_reg, rsp_next;

    logic [CNT_W:0]        lchild, rchild;
    logic [CNT_W-1:0]      parent;

    assign lchild = {idx_reg, 1'b1};
    assign rchild = {idx_reg, 1'b0} + (CNT_W+1)'(2);
    assign parent = (idx_reg - CNT_W'(1)) >> 1;
    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign rsp    = rsp_reg;
    assign count  = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        idx_reg   <= idx_next;
        oth_reg   <= oth_next;
        cur_reg   <= cur_next;
        lft_reg   <= lft_next;
        found_reg <= found_next;
        moved_reg <= moved_next;
        rsp_reg   <= rsp_next;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        oth_next   = oth_reg;
        cur_next   = cur_reg;
        lft_next   = lft_reg;
        found_next = found_reg;
        moved_next = moved_reg;
        rsp_next   = rsp_reg;
        mreq       = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    req_next.value = 64'(req.value[VALUE_WIDTH-1:0]);
                    rsp_next   = '0;
                    rsp_next.status = 1'b1;
                    idx_next   = '0;
                    found_next = 1'b0;
                    case (req.kind)
                        KIND_ADD, KIND_SET, KIND_DELETE, KIND_SEARCH:
                            state_next = (cnt_reg == '0) ? S_DISP : S_FIND;
                        KIND_MIN, KIND_EXTRACT:
                            state_next = (cnt_reg == '0) ? S_DONE : S_RDROOT;
                        KIND_MAX:
                        begin
                            idx_next   = cnt_reg >> 1;
                            oth_next   = cnt_reg >> 1;
                            state_next = (cnt_reg == '0) ? S_DONE : S_MXRD;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_FIND:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = idx_reg[IDX_W-1:0];
                state_next = S_FINDW;
            end
            S_FINDW:
            begin
                if (rdata.key == req_reg.key)
                begin
                    found_next = 1'b1;
                    lft_next   = rdata;
                    state_next = S_DISP;
                end
                else if (idx_reg + CNT_W'(1) >= cnt_reg)
                    state_next = S_DISP;
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_FIND;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (req_reg.kind)
                    KIND_ADD:
                    begin
                        if (!found_reg && cnt_reg != CNT_W'(CAPACITY))
                        begin
                            rsp_next.status = 1'b0;
                            cur_next   = '{key: req_reg.key,
                                           val: req_reg.value[VALUE_WIDTH-1:0]};
                            idx_next   = cnt_reg;
                            cnt_next   = cnt_reg + CNT_W'(1);
                            moved_next = 1'b0;
                            state_next = (cnt_reg == '0) ? S_PLACE : S_UPRD;
                        end
                    end
                    KIND_SET:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.status = 1'b0;
                            mreq.wr   = 1'b1;
                            mreq.addr = idx_reg[IDX_W-1:0];
                            mreq.wkey = lft_reg.key;
                            mreq.wval = req_reg.value[VALUE_WIDTH-1:0];
                        end
                    end
                    KIND_SEARCH:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.status       = 1'b0;
                            rsp_next.result_key   = req_reg.key;
                            rsp_next.position     = POS_W'(idx_reg);
                            rsp_next.result_value = 64'(lft_reg.val);
                        end
                    end
                    KIND_DELETE:
                    begin
                        if (found_reg)
                        begin
                            rsp_next.status = 1'b0;
                            cnt_next = cnt_reg - CNT_W'(1);
                            if (idx_reg != cnt_reg - CNT_W'(1))
                                state_next = S_RDLAST;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDLAST:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = cnt_reg[IDX_W-1:0];
                state_next = S_GOTLST;
            end
            S_GOTLST:
            begin
                cur_next   = rdata;
                moved_next = 1'b0;
                state_next = (idx_reg == '0) ? S_DNCHK : S_UPRD;
            end
            // Sift up: hole at idx, carried entry cur
            S_UPRD:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = parent[IDX_W-1:0];
                oth_next   = parent;
                state_next = S_UPCMP;
            end
            S_UPCMP:
            begin
                if (cur_reg.key < rdata.key)
                begin
                    lft_next   = rdata;
                    state_next = S_UPWR;
                end
                else
                    state_next = (moved_reg || req_reg.kind == KIND_ADD) ? S_PLACE
                                                                          : S_DNCHK;
            end
            S_UPWR:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = idx_reg[IDX_W-1:0];
                mreq.wkey  = lft_reg.key;
                mreq.wval  = lft_reg.val;
                idx_next   = oth_reg;
                moved_next = 1'b1;
                state_next = (oth_reg == '0) ? S_PLACE : S_UPRD;
            end
            // Sift down: hole at idx
            S_DNCHK:
            begin
                if (lchild >= {1'b0, cnt_reg})
                    state_next = S_PLACE;
                else
                    state_next = S_DNRDL;
            end
            S_DNRDL:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = lchild[IDX_W-1:0];
                state_next = S_DNGL;
            end
            S_DNGL:
            begin
                lft_next = rdata;
                oth_next = lchild[CNT_W-1:0];
                if (rchild < {1'b0, cnt_reg})
                begin
                    mreq.rd   = 1'b1;
                    mreq.addr = rchild[IDX_W-1:0];
                    state_next = S_DNRDR;
                end
                else
                    state_next = S_DNCMP;
            end
            S_DNRDR:
            begin
                if (rdata.key < lft_reg.key)
                begin
                    lft_next = rdata;
                    oth_next = rchild[CNT_W-1:0];
                end
                state_next = S_DNCMP;
            end
            S_DNCMP:
            begin
                if (lft_reg.key < cur_reg.key)
                    state_next = S_DNWR;
                else
                    state_next = S_PLACE;
            end
            S_DNWR:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = idx_reg[IDX_W-1:0];
                mreq.wkey  = lft_reg.key;
                mreq.wval  = lft_reg.val;
                idx_next   = oth_reg;
                state_next = S_DNCHK;
            end
            S_PLACE:
            begin
                mreq.wr    = 1'b1;
                mreq.addr  = idx_reg[IDX_W-1:0];
                mreq.wkey  = cur_reg.key;
                mreq.wval  = cur_reg.val;
                state_next = S_DONE;
            end
            // Min and extract read the root
            S_RDROOT:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = '0;
                state_next = S_ROOTW;
            end
            S_ROOTW:
            begin
                rsp_next.status       = 1'b0;
                rsp_next.result_key   = rdata.key;
                rsp_next.result_value = 64'(rdata.val);
                rsp_next.position     = '0;
                if (req_reg.kind == KIND_EXTRACT)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    idx_next   = '0;
                    state_next = (cnt_reg == CNT_W'(1)) ? S_DONE : S_RDLAST;
                end
                else
                    state_next = S_DONE;
            end
            // Max: scan leaves, oth holds best index
            S_MXRD:
            begin
                mreq.rd    = 1'b1;
                mreq.addr  = idx_reg[IDX_W-1:0];
                state_next = S_MXCMP;
            end
            S_MXCMP:
            begin
                if (idx_reg == oth_reg || lft_reg.key < rdata.key)
                begin
                    lft_next = rdata;
                    oth_next = idx_reg;
                end
                if (idx_reg + CNT_W'(1) >= cnt_reg)
                    state_next = S_MXOUT;
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_MXRD;
                end
            end
            S_MXOUT:
            begin
                rsp_next.status       = 1'b0;
                rsp_next.result_key   = lft_reg.key;
                rsp_next.position     = POS_W'(oth_reg);
                rsp_next.result_value = 64'(lft_reg.val);
                state_next            = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule
